### sv/two_class_round_robin_scheduler_macros.svh
// Assertion macros for the two-class round-robin scheduler; its datapath uses them.
// Define NO_ASSERTIONS to compile every macro below to nothing.
`ifndef TWO_CLASS_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TWO_CLASS_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
// An expression that must hold at every clock edge out of reset.
`define TCRR_ASSERT_HOLDS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("scheduler invariant violated");
// A consequence that must hold in the same cycle as its cause.
`define TCRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler implication violated");
// A consequence that must hold in the cycle after its cause.
`define TCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler next-cycle check violated");
`else
`define TCRR_ASSERT_HOLDS(label, clk, rst_n, expr)
`define TCRR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/tcrr_pkg.sv
// Shared constants, types and helpers of the two-class round-robin scheduler.
// No dependencies; every other source file but the macros header imports this package.
package tcrr_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int ID_W        = 8;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int COUNT_W     = 8;
	localparam int QUANTUM_W   = 16;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(100);

	// Request function codes.
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // a request word is taken this cycle
		logic add;        // append the request id to its class queue
		logic start;      // begin a slice on the highest-priority non-empty queue
		logic advance;    // count one tick of the running slice
		logic rotate_rd;  // quantum expired: read the head and end the slice
		logic rotate_wr;  // write the rotated id back at the tail
		logic load_out;   // load the result register
	} tcrr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic func;
		logic slice_active;
		logic both_empty;
		logic expire;
	} tcrr_stat_t;

	// Advance a ring pointer with wrap at the end of the ring.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

endpackage

### sv/tcrr_ifs.sv
// Valid/ready channel interfaces for scheduler request and result words.
// Depends on tcrr_pkg for the field widths.
interface tcrr_req_if import tcrr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            func;
	logic [ID_W-1:0] thread_id;
	logic            real_time_class;

	modport source (output valid, func, thread_id, real_time_class, input ready);
	modport sink (input valid, func, thread_id, real_time_class, output ready);
endinterface

interface tcrr_rsp_if import tcrr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               running_valid;
	logic [ID_W-1:0]    running_id;
	logic               running_class;
	logic               slice_ended;
	logic               add_rejected;
	logic [COUNT_W-1:0] real_time_count;
	logic [COUNT_W-1:0] general_count;

	modport source (output valid, running_valid, running_id, running_class, slice_ended,
		add_rejected, real_time_count, general_count, input ready);
	modport sink (input valid, running_valid, running_id, running_class, slice_ended,
		add_rejected, real_time_count, general_count, output ready);
endinterface

### sv/two_class_round_robin_scheduler.sv
// Two-class round-robin scheduler with strict priority of real-time over general ids.
// A request word is taken only while the block is idle; an add or an ordinary tick
// acts and then loads the result register, and the tick that ends a slice first
// reads the head id from its ring memory, then writes it back at the tail, then
// loads the result register. A result that is not taken holds the block in its
// hand-off cycle. There is no clearing pass after reset.
module two_class_round_robin_scheduler import tcrr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	tcrr_req_if.sink             req,
	tcrr_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [QUANTUM_W-1:0] cfg_wdata
);

	tcrr_cmd_t  cmd;
	tcrr_stat_t stat;

	// Sequencing.
	tcrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Queues, slice state and result register.
	tcrr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (req.func),
		.thread_id       (req.thread_id),
		.real_time_class (req.real_time_class),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.running_valid   (rsp.running_valid),
		.running_id      (rsp.running_id),
		.running_class   (rsp.running_class),
		.slice_ended     (rsp.slice_ended),
		.add_rejected    (rsp.add_rejected),
		.real_time_count (rsp.real_time_count),
		.general_count   (rsp.general_count)
	);

endmodule

### sv/tcrr_dp.sv
// Scheduler datapath: the two id rings, their pointers and fill counts, slice state,
// quantum register and result register. Depends on tcrr_pkg and the macros header.
`include "two_class_round_robin_scheduler_macros.svh"

module tcrr_dp import tcrr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcrr_cmd_t            cmd,
	output tcrr_stat_t           stat,
	input  logic                 func,
	input  logic [ID_W-1:0]      thread_id,
	input  logic                 real_time_class,
	input  logic                 cfg_we,
	input  logic [QUANTUM_W-1:0] cfg_wdata,
	output logic                 running_valid,
	output logic [ID_W-1:0]      running_id,
	output logic                 running_class,
	output logic                 slice_ended,
	output logic                 add_rejected,
	output logic [COUNT_W-1:0]   real_time_count,
	output logic [COUNT_W-1:0]   general_count
);

	logic [ID_W-1:0]      rt_ring [QUEUE_DEPTH];
	logic [ID_W-1:0]      gen_ring [QUEUE_DEPTH];
	logic [ID_W-1:0]      rt_rd_q, gen_rd_q;
	logic [PTR_W-1:0]     rt_head_q, rt_tail_q, gen_head_q, gen_tail_q;
	logic [FILL_W-1:0]    rt_fill_q, gen_fill_q;
	logic                 slice_active_q, slice_from_rt_q, rot_rt_q;
	logic [QUANTUM_W-1:0] elapsed_q, quantum_q, elapsed_inc;
	logic                 ended_q, rejected_q;
	logic                 rt_full, gen_full, rt_empty, gen_empty;
	logic                 rt_push, gen_push, rt_we, gen_we, rt_re, gen_re;
	logic [ID_W-1:0]      rt_wdata, gen_wdata;

	// Queue conditions and the tick comparison.
	assign rt_full     = (rt_fill_q == FILL_W'(QUEUE_DEPTH));
	assign gen_full    = (gen_fill_q == FILL_W'(QUEUE_DEPTH));
	assign rt_empty    = (rt_fill_q == '0);
	assign gen_empty   = (gen_fill_q == '0);
	assign elapsed_inc = elapsed_q + QUANTUM_W'(1);

	assign stat.func         = func;
	assign stat.slice_active = slice_active_q;
	assign stat.both_empty   = rt_empty && gen_empty;
	assign stat.expire       = (elapsed_inc >= quantum_q);

	// Ring port controls: pushes and write-backs go to the tail, reads come from the head.
	assign rt_push   = cmd.add && real_time_class && !rt_full;
	assign gen_push  = cmd.add && !real_time_class && !gen_full;
	assign rt_we     = rt_push || (cmd.rotate_wr && rot_rt_q);
	assign gen_we    = gen_push || (cmd.rotate_wr && !rot_rt_q);
	assign rt_wdata  = cmd.rotate_wr ? rt_rd_q : thread_id;
	assign gen_wdata = cmd.rotate_wr ? gen_rd_q : thread_id;
	assign rt_re     = (cmd.start && !rt_empty) || (cmd.rotate_rd && slice_from_rt_q);
	assign gen_re    = (cmd.start && rt_empty) || (cmd.rotate_rd && !slice_from_rt_q);

	// Real-time ring memory with registered read.
	always_ff @(posedge clk) begin
		if (rt_we) begin
			rt_ring[rt_tail_q] <= rt_wdata;
		end
		if (rt_re) begin
			rt_rd_q <= rt_ring[rt_head_q];
		end
	end

	// General ring memory with registered read.
	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_ring[gen_tail_q] <= gen_wdata;
		end
		if (gen_re) begin
			gen_rd_q <= gen_ring[gen_head_q];
		end
	end

	// Pointers and fill counts. A rotation moves the head, then the tail, and keeps the fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_head_q  <= '0;
			rt_tail_q  <= '0;
			rt_fill_q  <= '0;
			gen_head_q <= '0;
			gen_tail_q <= '0;
			gen_fill_q <= '0;
		end else begin
			if (rt_push) begin
				rt_fill_q <= rt_fill_q + FILL_W'(1);
			end
			if (gen_push) begin
				gen_fill_q <= gen_fill_q + FILL_W'(1);
			end
			if (rt_we) begin
				rt_tail_q <= ptr_next(rt_tail_q);
			end
			if (gen_we) begin
				gen_tail_q <= ptr_next(gen_tail_q);
			end
			if (cmd.rotate_rd && slice_from_rt_q) begin
				rt_head_q <= ptr_next(rt_head_q);
			end
			if (cmd.rotate_rd && !slice_from_rt_q) begin
				gen_head_q <= ptr_next(gen_head_q);
			end
		end
	end

	// Slice state, tick counter and per-word flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_active_q  <= 1'b0;
			slice_from_rt_q <= 1'b0;
			rot_rt_q        <= 1'b0;
			elapsed_q       <= '0;
			ended_q         <= 1'b0;
			rejected_q      <= 1'b0;
		end else begin
			if (cmd.capture) begin
				ended_q    <= cmd.rotate_rd;
				rejected_q <= cmd.add && (real_time_class ? rt_full : gen_full);
			end
			if (cmd.start) begin
				slice_active_q  <= 1'b1;
				slice_from_rt_q <= !rt_empty;
				elapsed_q       <= '0;
			end else if (cmd.advance) begin
				elapsed_q <= elapsed_inc;
			end else if (cmd.rotate_rd) begin
				rot_rt_q        <= slice_from_rt_q;
				slice_active_q  <= 1'b0;
				slice_from_rt_q <= 1'b0;
				elapsed_q       <= '0;
			end
		end
	end

	// Quantum register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	// Result register, loaded once all updates of the word are done.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			running_valid   <= slice_active_q;
			running_id      <= slice_active_q ? (slice_from_rt_q ? rt_rd_q : gen_rd_q) : '0;
			running_class   <= slice_active_q && slice_from_rt_q;
			slice_ended     <= ended_q;
			add_rejected    <= rejected_q;
			real_time_count <= COUNT_W'(rt_fill_q);
			general_count   <= COUNT_W'(gen_fill_q);
		end
	end

	`TCRR_ASSERT_HOLDS(a_fill_bound, clk, arst_n,
		(rt_fill_q <= FILL_W'(QUEUE_DEPTH)) && (gen_fill_q <= FILL_W'(QUEUE_DEPTH)))
	`TCRR_ASSERT_IMPL(a_active_nonempty, clk, arst_n, slice_active_q,
		(slice_from_rt_q ? !rt_empty : !gen_empty))
	`TCRR_ASSERT_NEXT(a_rotate_keeps_fill, clk, arst_n, cmd.rotate_rd || cmd.rotate_wr,
		$stable(rt_fill_q) && $stable(gen_fill_q))

endmodule

### sv/tcrr_ctrl.sv
// Scheduler controller: sequences each request word through act, optional
// write-back and result hand-off. Depends on tcrr_pkg.
module tcrr_ctrl import tcrr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  tcrr_stat_t stat,
	output tcrr_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ROTATE = 3'b010,
		ST_FINISH = 3'b100
	} tcrr_state_t;

	tcrr_state_t state_q, state_d;
	logic        out_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_FINISH;
					if (stat.func == FUNC_ADD) begin
						cmd.add = 1'b1;
					end else if (!stat.slice_active) begin
						cmd.start = !stat.both_empty;
					end else if (stat.expire) begin
						cmd.rotate_rd = 1'b1;
						state_d       = ST_ROTATE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			ST_ROTATE: begin
				cmd.rotate_wr = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### dv/tcrr_sched_checker.sv
// Checker for the two-class round-robin scheduler: watches the request, result and
// configuration ports, predicts every status word and compares it field by field.
// Depends on tcrr_pkg and on the channel interfaces in tcrr_ifs.sv.
module tcrr_sched_checker import tcrr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	tcrr_req_if                  req,
	tcrr_rsp_if                  rsp,
	input  logic                 cfg_we,
	input  logic [QUANTUM_W-1:0] cfg_wdata,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// One status word as the block reports it after a request.
	typedef struct packed {
		logic               running_valid;
		logic [ID_W-1:0]    running_id;
		logic               running_class;
		logic               slice_ended;
		logic               add_rejected;
		logic [COUNT_W-1:0] real_time_count;
		logic [COUNT_W-1:0] general_count;
	} sched_status_t;

	// Shadow copy of the scheduler state.
	logic [ID_W-1:0]      rt_ids [QUEUE_DEPTH];
	logic [ID_W-1:0]      gen_ids [QUEUE_DEPTH];
	int                   rt_rd, rt_wr, rt_cnt;
	int                   gen_rd, gen_wr, gen_cnt;
	logic                 slice_on, slice_rt;
	logic [QUANTUM_W-1:0] ticks_run;
	logic [QUANTUM_W-1:0] quantum;

	sched_status_t expected_status_q[$];

	// Apply one request word to the shadow state and work out the status it causes.
	task automatic predict_status(input logic fn, input logic [ID_W-1:0] id,
			input logic to_rt, output sched_status_t st);
		logic ended;
		logic dropped;
		ended = 1'b0;
		dropped = 1'b0;
		if (fn == FUNC_ADD) begin
			if (to_rt) begin
				if (rt_cnt >= QUEUE_DEPTH) begin
					dropped = 1'b1;
				end else begin
					rt_ids[rt_wr] = id;
					rt_wr = (rt_wr + 1) % QUEUE_DEPTH;
					rt_cnt++;
				end
			end else begin
				if (gen_cnt >= QUEUE_DEPTH) begin
					dropped = 1'b1;
				end else begin
					gen_ids[gen_wr] = id;
					gen_wr = (gen_wr + 1) % QUEUE_DEPTH;
					gen_cnt++;
				end
			end
		end else if (!slice_on) begin
			// A new slice goes to the real-time head first, else the general head.
			if (rt_cnt > 0) begin
				slice_on = 1'b1;
				slice_rt = 1'b1;
				ticks_run = '0;
			end else if (gen_cnt > 0) begin
				slice_on = 1'b1;
				slice_rt = 1'b0;
				ticks_run = '0;
			end
		end else begin
			ticks_run = ticks_run + QUANTUM_W'(1);
			if (ticks_run >= quantum) begin
				// The granted head moves to the tail of its own ring; the fill stays.
				if (slice_rt && rt_cnt != 0) begin
					rt_ids[rt_wr] = rt_ids[rt_rd];
					rt_rd = (rt_rd + 1) % QUEUE_DEPTH;
					rt_wr = (rt_wr + 1) % QUEUE_DEPTH;
				end else if (!slice_rt && gen_cnt != 0) begin
					gen_ids[gen_wr] = gen_ids[gen_rd];
					gen_rd = (gen_rd + 1) % QUEUE_DEPTH;
					gen_wr = (gen_wr + 1) % QUEUE_DEPTH;
				end
				slice_on = 1'b0;
				slice_rt = 1'b0;
				ticks_run = '0;
				ended = 1'b1;
			end
		end
		st.running_valid = slice_on;
		if (slice_on) begin
			st.running_id = slice_rt ? rt_ids[rt_rd] : gen_ids[gen_rd];
			st.running_class = slice_rt;
		end else begin
			st.running_id = '0;
			st.running_class = 1'b0;
		end
		st.slice_ended = ended;
		st.add_rejected = dropped;
		st.real_time_count = COUNT_W'(rt_cnt);
		st.general_count = COUNT_W'(gen_cnt);
	endtask

	// Report one field that differs from its prediction.
	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Results are retired before new words are predicted, since a result taken at
	// the same edge as a request always belongs to an earlier request.
	always @(posedge clk or negedge arst_n) begin
		sched_status_t want;
		sched_status_t pred;
		if (!arst_n) begin
			expected_status_q.delete();
			rt_rd = 0;
			rt_wr = 0;
			rt_cnt = 0;
			gen_rd = 0;
			gen_wr = 0;
			gen_cnt = 0;
			slice_on = 1'b0;
			slice_rt = 1'b0;
			ticks_run = '0;
			quantum = QUANTUM_RESET;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_status_q.size() == 0) begin
					$display("%0t: status word with none expected, actual running_id %0d",
						$time, rsp.running_id);
					mismatches++;
				end else begin
					want = expected_status_q.pop_front();
					compare_field("running_valid", want.running_valid, rsp.running_valid);
					compare_field("running_id", want.running_id, rsp.running_id);
					compare_field("running_class", want.running_class, rsp.running_class);
					compare_field("slice_ended", want.slice_ended, rsp.slice_ended);
					compare_field("add_rejected", want.add_rejected, rsp.add_rejected);
					compare_field("real_time_count", want.real_time_count,
						rsp.real_time_count);
					compare_field("general_count", want.general_count, rsp.general_count);
				end
			end
			if (req.valid && req.ready) begin
				predict_status(req.func, req.thread_id, req.real_time_class, pred);
				expected_status_q.push_back(pred);
			end
			if (cfg_we) begin
				quantum = cfg_wdata;
			end
			outstanding <= expected_status_q.size();
		end
	end

endmodule

### dv/two_class_round_robin_scheduler_tb.sv
// Top of the scheduler testbench: clock, reset, request words, quantum writes and
// result back-pressure, with the verdict. Depends on tcrr_pkg, tcrr_ifs.sv, the
// scheduler RTL and tcrr_sched_checker.sv.
module two_class_round_robin_scheduler_tb import tcrr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [QUANTUM_W-1:0] cfg_wdata;
	int                   sender_idle_pct;
	int                   receiver_idle_pct;
	int                   mismatches;
	int                   outstanding;
	int                   quiet_cycles;

	tcrr_req_if req();
	tcrr_rsp_if rsp();

	two_class_round_robin_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tcrr_sched_checker status_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random at the current rate.
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	// End the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Offer one request word, idling first at the current rate, and wait for it to go.
	task automatic send_word(input logic fn, input logic [ID_W-1:0] id, input logic to_rt);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.thread_id <= id;
		req.real_time_class <= to_rt;
		do @(posedge clk); while (!req.ready);
	endtask

	// Random words: tick_pct percent ticks, rt_pct percent of words aimed at real time.
	task automatic issue_random(input int count, input int tick_pct, input int rt_pct);
		logic fn;
		for (int i = 0; i < count; i++) begin
			fn = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_ADD;
			send_word(fn, ID_W'($urandom_range(0, 255)), $urandom_range(0, 99) < rt_pct);
		end
	endtask

	// Hold off new words until every status word has come back and the block is idle.
	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.func = FUNC_ADD;
		req.thread_id = '0;
		req.real_time_class = 1'b0;
		sender_idle_pct = 33;
		receiver_idle_pct = 51;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset quantum: a tick on empty queues, id extremes, then a general slice.
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_ADD, 8'hFF, 1'b0);
		send_word(FUNC_ADD, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'hFF, 1'b1);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		issue_random(250, 85, 0);

		// A zero quantum ends each slice on the first tick after it starts.
		write_quantum('0);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_ADD, 8'h80, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);

		// Smallest nonzero quantum, general ids only, then real-time ids arrive mid-slice.
		write_quantum(16'd1);
		issue_random(150, 60, 0);
		send_word(FUNC_ADD, 8'h01, 1'b1);
		send_word(FUNC_ADD, 8'hFE, 1'b1);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);
		send_word(FUNC_TICK, 8'h00, 1'b0);

		// Longest quantum, then a short one written while a slice is long past it;
		// the add-heavy words fill the real-time ring and overflow it.
		sender_idle_pct = 51;
		receiver_idle_pct = 33;
		write_quantum(16'hFFFF);
		issue_random(250, 50, 50);
		write_quantum(16'd3);
		issue_random(200, 30, 70);

		// No idling: mostly ticks, rotating a full real-time ring.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_quantum(16'd2);
		issue_random(300, 80, 50);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### two_class_round_robin_scheduler.f
+incdir+sv
sv/tcrr_pkg.sv
sv/tcrr_ifs.sv
sv/tcrr_dp.sv
sv/tcrr_ctrl.sv
sv/two_class_round_robin_scheduler.sv
dv/tcrr_sched_checker.sv
dv/two_class_round_robin_scheduler_tb.sv
